[rtl/lomx_pkg.sv]
// Shared types and constants for the order book matcher.
// Depends on nothing; every other file imports it.
`default_nettype none

package lomx_pkg;

  localparam int unsigned PRICE_LEVELS = 1024;
  localparam logic [9:0]  PX_MAX       = 10'(PRICE_LEVELS - 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_BOOK_FULL = 2'd2;
  localparam logic [1:0] STS_DUP_ID    = 2'd3;

  localparam logic REC_TRADE  = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] order_id;
    logic        is_sell;
    logic        is_market;
    logic [9:0]  price_tick;
    logic [23:0] quantity;
  } req_t;

  typedef struct packed {
    logic        rec_kind;
    logic [1:0]  status;
    logic [31:0] taker_id;
    logic [31:0] maker_id;
    logic [9:0]  trade_price;
    logic [23:0] trade_qty;
    logic        last;
    logic [9:0]  top_bid;
    logic        bid_present;
    logic [9:0]  top_ask;
    logic        ask_present;
  } res_t;

  // One resting order held in a cell.
  typedef struct packed {
    logic        used;
    logic        sell;
    logic [31:0] id;
    logic [23:0] qty;
    logic [9:0]  price;
  } cell_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INS,
    OP_DEL,
    OP_SETQ,
    OP_CLR
  } op_e;

  // Broadcast command; x carries the request id for matching, the order
  // to insert, the side of a delete and the new quantity of an update.
  typedef struct packed {
    op_e   op;
    cell_t x;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MATCH,
    ST_REST,
    ST_FINISH
  } st_e;

  // Virtual neighbors past both ends of the chain: a bid that always
  // stays ahead on the left, an ask that always stays ahead on the right.
  localparam cell_t LEFT_EDGE  = '{used: 1'b1, sell: 1'b0, id: '0, qty: '0, price: '1};
  localparam cell_t RIGHT_EDGE = '{used: 1'b1, sell: 1'b1, id: '0, qty: '0, price: '0};

endpackage

`default_nettype wire

[rtl/lomx_if.sv]
// Request and result channel interfaces for the order book matcher.
// Depends on lomx_pkg.
`default_nettype none

interface lomx_req_if;
  import lomx_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lomx_res_if;
  import lomx_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/limit_order_book_matcher_core.sv]
// An add or re-adding modify steps from accept through decode, match check
// (repeated for each fill), rest and finish to the final result; cancel, clear,
// in-place modify and rejected requests go from decode straight to finish. One
// request at a time: the next is taken once the sequencer is back in idle after
// the final result loads; a held output stalls fills and finish. Reset empties all cells.
// Depends on lomx_pkg, lomx_if and lomx_cell.
`default_nettype none

module limit_order_book_matcher_core #(
  parameter int unsigned ORDER_SLOTS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lomx_req_if.sink    req_i,
  lomx_res_if.source  res_o
);
  import lomx_pkg::*;

  localparam int unsigned N = ORDER_SLOTS;
  localparam logic [16:0] LEVELS = 17'(PRICE_LEVELS);
  localparam logic [N-1:0] ONE_N = {{(N-1){1'b0}}, 1'b1};
  localparam logic [N-1:0] TOP_N = {1'b1, {(N-1){1'b0}}};

  // Order chain. Bids pack from the left end in priority order (highest
  // price first, oldest first within a price); asks pack from the right end
  // (lowest price at the far right). The best of each side is always at a
  // fixed end cell, so matching reads the ends only.
  cell_t        cell_q [N];
  cell_t        sel_v  [N];
  logic [N-1:0] hit_v, used_v, tgt, shift_v, tgt_m1;
  cmd_t         cmd;
  cell_t        sel;
  logic         hit_any;

  for (genvar i = 0; i < N; i++) begin : g_cell
    cell_t left_s, right_s;
    if (i == 0) begin : g_l_edge
      assign left_s = LEFT_EDGE;
    end else begin : g_l_cell
      assign left_s = cell_q[i-1];
    end
    if (i == N - 1) begin : g_r_edge
      assign right_s = RIGHT_EDGE;
    end else begin : g_r_cell
      assign right_s = cell_q[i+1];
    end
    lomx_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .tgt_i   (tgt[i]),
      .shift_i (shift_v[i]),
      .left_i  (left_s),
      .right_i (right_s),
      .state_o (cell_q[i]),
      .hit_o   (hit_v[i]),
      .sel_o   (sel_v[i])
    );
    assign used_v[i] = cell_q[i].used;
  end

  // Fields of the order whose id matches the request (at most one).
  always_comb begin
    sel = '0;
    for (int i = 0; i < N; i++) begin
      sel = sel | sel_v[i];
    end
  end
  assign hit_any = |hit_v;

  // Delete shifts bids left from the target on, asks right up to it.
  assign tgt_m1  = tgt - ONE_N;
  assign shift_v = cmd.x.sell ? (tgt | tgt_m1) : ~tgt_m1;

  // Sequencer state
  st_e         state_q, state_d;
  req_t        req_q;
  logic [9:0]  px_q, px_in;
  logic        side_q, side_d, mkt_q, mkt_d;
  logic [23:0] rem_q, rem_d;
  logic [1:0]  status_q, status_d;
  res_t        pend_q, pend_d;
  logic        pend_valid_q, pend_valid_d;
  res_t        res_q, res_d;
  logic        out_valid_q, out_valid_d, out_load;
  logic        req_acc;

  cell_t       head_b, head_a, opp;
  logic        bid_here, ask_here, opp_here, crosses, fill_go, fill_stall;
  logic        out_free, in_place;
  logic [23:0] fill_qty;
  logic [N-1:0] head_tgt;

  assign req_acc  = req_i.valid & req_i.ready;
  assign px_in    = ({7'd0, req_i.payload.price_tick} >= LEVELS) ? PX_MAX
                                                                  : req_i.payload.price_tick;

  assign head_b   = cell_q[0];
  assign head_a   = cell_q[N-1];
  assign bid_here = head_b.used & ~head_b.sell;
  assign ask_here = head_a.used & head_a.sell;

  // A seller hits the bid end, a buyer lifts the ask end.
  assign opp      = side_q ? head_b : head_a;
  assign opp_here = side_q ? bid_here : ask_here;
  assign head_tgt = side_q ? ONE_N : TOP_N;
  assign crosses  = mkt_q | (side_q ? (opp.price >= px_q) : (opp.price <= px_q));
  assign fill_go  = (rem_q != 24'd0) & opp_here & crosses;
  assign fill_qty = (rem_q < opp.qty) ? rem_q : opp.qty;

  // A held trade can only move on when the output register frees up.
  assign out_free   = ~out_valid_q | res_o.ready;
  assign fill_stall = pend_valid_q & ~out_free;

  assign in_place = (sel.price == px_q) && (req_q.quantity != 24'd0) &&
                    (req_q.quantity <= sel.qty);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (req_q.req_type)
          REQ_ADD:    state_d = hit_any ? ST_FINISH : ST_MATCH;
          REQ_MODIFY: state_d = (!hit_any || in_place) ? ST_FINISH : ST_MATCH;
          default:    state_d = ST_FINISH;
        endcase
      end
      ST_MATCH: begin
        if (!fill_go) state_d = ST_REST;
      end
      ST_REST: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Chain commands and datapath updates
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NOP;
    cmd.x        = '{used: 1'b1, sell: side_q, id: req_q.order_id, qty: rem_q,
                     price: px_q};
    tgt          = '0;
    side_d       = side_q;
    mkt_d        = mkt_q;
    rem_d        = rem_q;
    status_d     = status_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_load     = 1'b0;
    res_d        = res_q;
    case (state_q)
      ST_IDLE: begin
        status_d     = STS_OK;
        pend_valid_d = 1'b0;
      end
      ST_DECODE: begin
        rem_d  = req_q.quantity;
        side_d = req_q.is_sell;
        mkt_d  = req_q.is_market;
        case (req_q.req_type)
          REQ_ADD: begin
            if (hit_any) status_d = STS_DUP_ID;
          end
          REQ_CANCEL: begin
            if (!hit_any) begin
              status_d = STS_NOT_FOUND;
            end else begin
              cmd.op     = OP_DEL;
              cmd.x.sell = sel.sell;
              tgt        = hit_v;
            end
          end
          REQ_MODIFY: begin
            side_d = sel.sell;
            mkt_d  = 1'b0;
            if (!hit_any) begin
              status_d = STS_NOT_FOUND;
            end else if (in_place) begin
              cmd.op    = OP_SETQ;
              cmd.x.qty = req_q.quantity;
              tgt       = hit_v;
            end else begin
              // cancel, then re-add as a limit order on the old side
              cmd.op     = OP_DEL;
              cmd.x.sell = sel.sell;
              tgt        = hit_v;
            end
          end
          default: begin
            cmd.op = OP_CLR;
          end
        endcase
      end
      ST_MATCH: begin
        if (fill_go && !fill_stall) begin
          // push the previous trade out; the newest one is held until we
          // know whether it is the final result
          if (pend_valid_q) begin
            out_load = 1'b1;
            res_d    = pend_q;
          end
          pend_d             = '0;
          pend_d.rec_kind    = REC_TRADE;
          pend_d.taker_id    = req_q.order_id;
          pend_d.maker_id    = opp.id;
          pend_d.trade_price = opp.price;
          pend_d.trade_qty   = fill_qty;
          pend_valid_d       = 1'b1;
          rem_d              = rem_q - fill_qty;
          tgt                = head_tgt;
          if (fill_qty == opp.qty) begin
            cmd.op     = OP_DEL;
            cmd.x.sell = ~side_q;
          end else begin
            cmd.op    = OP_SETQ;
            cmd.x.qty = opp.qty - fill_qty;
          end
        end
      end
      ST_REST: begin
        if (rem_q != 24'd0 && !mkt_q) begin
          if (&used_v) begin
            status_d = STS_BOOK_FULL;
          end else begin
            cmd.op = OP_INS;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_q) begin
            res_d = pend_q;
          end else begin
            res_d          = '0;
            res_d.rec_kind = REC_STATUS;
          end
          res_d.status      = status_q;
          res_d.last        = 1'b1;
          res_d.top_bid     = bid_here ? head_b.price : 10'd0;
          res_d.bid_present = bid_here;
          res_d.top_ask     = ask_here ? head_a.price : 10'd0;
          res_d.ask_present = ask_here;
          pend_valid_d      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q <= req_i.payload;
      px_q  <= px_in;
    end
    side_q   <= side_d;
    mkt_q    <= mkt_d;
    rem_q    <= rem_d;
    status_q <= status_d;
    pend_q   <= pend_d;
    if (out_load) res_q <= res_d;
  end

  assign req_i.ready   = (state_q == ST_IDLE);
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = res_q;

  // Resting only happens when a cell is free.
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_INS) |-> !(&used_v))
    else $error("insert into a full chain");

  // A delete names exactly one cell.
  a_del_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_DEL) |-> $onehot(tgt))
    else $error("delete target not one-hot");

  // Live ids are unique.
  a_id_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_v))
    else $error("duplicate live order id");

  // No held trade survives a finished request.
  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("trade held while idle");

  // The resting book is never crossed between requests.
  a_no_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && bid_here && ask_here) |-> (head_b.price < head_a.price))
    else $error("crossed book at rest");

endmodule

`default_nettype wire

[rtl/lomx_cell.sv]
// One order cell of the sorted book chain: holds one order, shifts with
// its neighbors on insert and delete. Depends on lomx_pkg.
`default_nettype none

module lomx_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lomx_pkg::cmd_t   cmd_i,
  input  logic             tgt_i,
  input  logic             shift_i,
  input  lomx_pkg::cell_t  left_i,
  input  lomx_pkg::cell_t  right_i,
  output lomx_pkg::cell_t  state_o,
  output logic             hit_o,
  output lomx_pkg::cell_t  sel_o
);
  import lomx_pkg::*;

  logic        used_q, sell_q;
  logic [31:0] id_q;
  logic [23:0] qty_q;
  logic [9:0]  price_q;
  cell_t       cur, nxt;
  logic        me_bid, me_ask, l_bid, l_ask, r_bid, r_ask;
  logic        me_stay_b, l_stay_b, me_stay_a, r_stay_a;

  assign cur = '{used: used_q, sell: sell_q, id: id_q, qty: qty_q, price: price_q};

  assign me_bid = cur.used & ~cur.sell;
  assign me_ask = cur.used & cur.sell;
  assign l_bid  = left_i.used & ~left_i.sell;
  assign l_ask  = left_i.used & left_i.sell;
  assign r_bid  = right_i.used & ~right_i.sell;
  assign r_ask  = right_i.used & right_i.sell;

  // Stay ahead of a new order: better price, or same price and older.
  assign me_stay_b = me_bid & (cur.price >= cmd_i.x.price);
  assign l_stay_b  = l_bid & (left_i.price >= cmd_i.x.price);
  assign me_stay_a = me_ask & (cur.price <= cmd_i.x.price);
  assign r_stay_a  = r_ask & (right_i.price <= cmd_i.x.price);

  always_comb begin
    nxt = cur;
    case (cmd_i.op)
      OP_INS: begin
        if (!cmd_i.x.sell) begin
          if (l_bid && !me_stay_b) begin
            nxt = l_stay_b ? cmd_i.x : left_i;
          end
        end else begin
          if (r_ask && !me_stay_a) begin
            nxt = r_stay_a ? cmd_i.x : right_i;
          end
        end
      end
      OP_DEL: begin
        if (shift_i && !cmd_i.x.sell && me_bid) begin
          if (r_bid) nxt = right_i;
          else nxt.used = 1'b0;
        end else if (shift_i && cmd_i.x.sell && me_ask) begin
          if (l_ask) nxt = left_i;
          else nxt.used = 1'b0;
        end
      end
      OP_SETQ: begin
        if (tgt_i) nxt.qty = cmd_i.x.qty;
      end
      OP_CLR: begin
        nxt.used = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= nxt.used;
    end
  end

  always_ff @(posedge clk_i) begin
    sell_q  <= nxt.sell;
    id_q    <= nxt.id;
    qty_q   <= nxt.qty;
    price_q <= nxt.price;
  end

  assign state_o = cur;
  assign hit_o   = cur.used & (cur.id == cmd_i.x.id);
  assign sel_o   = hit_o ? cur : '0;

endmodule

`default_nettype wire
